@@ hw/rtl/bnb_pkg.sv @@
`default_nettype none

package bnb_pkg;

    // Payload widths
    localparam int KIND_W    = 1;
    localparam int SEL_W     = 2;
    localparam int CLS_W     = 4;
    localparam int FIDX_W    = 5;
    localparam int VAL_W     = 32;
    localparam int BITS_W    = 32;
    localparam int CC_W      = 5;
    localparam int FC_W      = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 6;

    // Parameter defaults
    localparam int MAX_CLASSES_DEF  = 16;
    localparam int MAX_FEATURES_DEF = 32;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_WRITE    = 1'b0;
    localparam logic [KIND_W-1:0] KIND_CLASSIFY = 1'b1;

    // Table selects
    localparam logic [SEL_W-1:0] TBL_PRIOR   = 2'd0;
    localparam logic [SEL_W-1:0] TBL_PRESENT = 2'd1;
    localparam logic [SEL_W-1:0] TBL_ABSENT  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 1'b1;

    // Register reset values
    localparam logic [CC_W-1:0] CLASS_COUNT_RST   = 5'd2;
    localparam logic [FC_W-1:0] FEATURE_COUNT_RST = 6'd2;

    // Saturation limits
    localparam logic signed [VAL_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] S32_MIN = 32'sh8000_0000;

    // Tag that travels with each table read
    typedef struct packed {
        logic             valid;   // a read was issued this cycle
        logic             first;   // first term of a class: start from prior
        logic             last;    // last term of a class
        logic             lastc;   // last term of the last class
        logic             nofeat;  // no features in use: score is the prior
        logic             on;      // feature bit set: take present term
        logic [CLS_W-1:0] cls;
    } t_tag;

endpackage

`default_nettype wire

@@ hw/rtl/bnb_item_if.sv @@
`default_nettype none

interface bnb_item_if;
    logic                            valid;
    logic                            ready;
    logic [bnb_pkg::KIND_W-1:0]      kind;
    logic [bnb_pkg::SEL_W-1:0]       table_sel;
    logic [bnb_pkg::CLS_W-1:0]       class_index;
    logic [bnb_pkg::FIDX_W-1:0]      feature_index;
    logic signed [bnb_pkg::VAL_W-1:0] entry_value;
    logic [bnb_pkg::BITS_W-1:0]      feature_bits;

    modport source (output valid, kind, table_sel, class_index, feature_index,
                    entry_value, feature_bits, input ready);
    modport sink   (input valid, kind, table_sel, class_index, feature_index,
                    entry_value, feature_bits, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bnb_result_if.sv @@
`default_nettype none

interface bnb_result_if;
    logic                             valid;
    logic                             ready;
    logic [bnb_pkg::CLS_W-1:0]        best_class;
    logic signed [bnb_pkg::VAL_W-1:0] win_score;

    modport source (output valid, best_class, win_score, input ready);
    modport sink   (input valid, best_class, win_score, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bnb_cfg_if.sv @@
`default_nettype none

interface bnb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bnb_pkg::CFG_IDX_W-1:0]  index;
    logic [bnb_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bernoulli_bayes_classifier.sv @@
// Flow: a classify sweeps classes_in_use * max(features_in_use, 1) table entries, one
// table read a cycle feeding one shared saturating adder, then the best class is loaded
// into the output register; a table write gives no result. No new item is taken from a
// classify's acceptance until its result is loaded; writes one per cycle otherwise.
// Reset: control state clears, class_count and feature_count return to 2; the log tables
// are not cleared and hold no defined value until written.
`default_nettype none

module bernoulli_bayes_classifier #(
    parameter int MAX_CLASSES  = bnb_pkg::MAX_CLASSES_DEF,
    parameter int MAX_FEATURES = bnb_pkg::MAX_FEATURES_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    bnb_item_if.sink     i_item,
    bnb_cfg_if.sink      i_cfg,
    bnb_result_if.source o_result
);

    import bnb_pkg::*;

    localparam int JW     = $clog2(MAX_FEATURES+1);
    localparam int AW     = $clog2(MAX_CLASSES*MAX_FEATURES);
    localparam int CAW    = $clog2(MAX_CLASSES);
    localparam int CLIMIT = (MAX_CLASSES < 16) ? MAX_CLASSES : 16;
    localparam int DEPTH  = MAX_CLASSES*MAX_FEATURES;

    logic [CC_W-1:0] r_class_count;
    logic [FC_W-1:0] r_feature_count;
    logic            r_busy;
    logic            r_hold;
    logic            r_out_valid;
    logic [CLS_W-1:0]        r_out_cls;
    logic signed [VAL_W-1:0] r_out_score;

    logic            item_acc, wr_acc, cls_acc;
    logic            cls_ok, feat_ok;
    logic            prior_we, present_we, absent_we;
    logic [CAW-1:0]  prior_waddr, prior_raddr;
    logic [AW-1:0]   feat_waddr, feat_raddr;
    logic [VAL_W-1:0] prior_rd, present_rd, absent_rd;
    logic [CC_W-1:0] nc;
    logic [JW-1:0]   nf;
    t_tag            tag;
    logic            done;
    logic [CLS_W-1:0]        best_cls;
    logic signed [VAL_W-1:0] win_score;
    logic            out_free, out_load;

    // Input handshake and write decode
    assign i_item.ready = !r_busy;
    assign item_acc     = i_item.valid && !r_busy;
    assign wr_acc       = item_acc && (i_item.kind == KIND_WRITE);
    assign cls_acc      = item_acc && (i_item.kind == KIND_CLASSIFY);

    always_comb begin
        cls_ok      = int'(i_item.class_index) < MAX_CLASSES;
        feat_ok     = int'(i_item.feature_index) < MAX_FEATURES;
        prior_we    = wr_acc && cls_ok && (i_item.table_sel == TBL_PRIOR);
        present_we  = wr_acc && cls_ok && feat_ok && (i_item.table_sel == TBL_PRESENT);
        absent_we   = wr_acc && cls_ok && feat_ok && (i_item.table_sel == TBL_ABSENT);
        prior_waddr = CAW'(i_item.class_index);
        feat_waddr  = AW'(int'(i_item.class_index) * MAX_FEATURES
                          + int'(i_item.feature_index));
    end

    // Effective class and feature counts
    always_comb begin
        if (r_class_count == '0) begin
            nc = CC_W'(1);
        end else if (int'(r_class_count) > CLIMIT) begin
            nc = CC_W'(CLIMIT);
        end else begin
            nc = r_class_count;
        end
        if (int'(r_feature_count) > MAX_FEATURES) begin
            nf = JW'(MAX_FEATURES);
        end else begin
            nf = JW'(r_feature_count);
        end
    end

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_count   <= CLASS_COUNT_RST;
            r_feature_count <= FEATURE_COUNT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_CLASS_COUNT:   r_class_count   <= i_cfg.data[CC_W-1:0];
                CFG_FEATURE_COUNT: r_feature_count <= i_cfg.data[FC_W-1:0];
                default: ;
            endcase
        end
    end

    // Log tables
    bnb_ram #(.WIDTH(VAL_W), .DEPTH(MAX_CLASSES)) u_prior (
        .i_clk   (i_clk),
        .i_we    (prior_we),
        .i_waddr (prior_waddr),
        .i_wdata (i_item.entry_value),
        .i_raddr (prior_raddr),
        .o_rdata (prior_rd)
    );

    bnb_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_present (
        .i_clk   (i_clk),
        .i_we    (present_we),
        .i_waddr (feat_waddr),
        .i_wdata (i_item.entry_value),
        .i_raddr (feat_raddr),
        .o_rdata (present_rd)
    );

    bnb_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_absent (
        .i_clk   (i_clk),
        .i_we    (absent_we),
        .i_waddr (feat_waddr),
        .i_wdata (i_item.entry_value),
        .i_raddr (feat_raddr),
        .o_rdata (absent_rd)
    );

    // Sweep sequencer
    bnb_seq #(.MAX_CLASSES(MAX_CLASSES), .MAX_FEATURES(MAX_FEATURES)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (cls_acc),
        .i_nc         (nc),
        .i_nf         (nf),
        .i_bits       (i_item.feature_bits),
        .o_prior_addr (prior_raddr),
        .o_feat_addr  (feat_raddr),
        .o_tag        (tag)
    );

    // Accumulate and pick the best class
    bnb_acc u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (tag),
        .i_prior     (prior_rd),
        .i_present   (present_rd),
        .i_absent    (absent_rd),
        .o_done      (done),
        .o_best_cls  (best_cls),
        .o_win_score (win_score)
    );

    // Output register; the winner waits in the datapath if it is still full
    assign out_free = !r_out_valid || o_result.ready;
    assign out_load = (done || r_hold) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_hold      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cls_acc) begin
                r_busy <= 1'b1;
            end else if (out_load) begin
                r_busy <= 1'b0;
            end
            r_hold <= (done || r_hold) && !out_free;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (out_load) begin
            r_out_cls   <= best_cls;
            r_out_score <= win_score;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.best_class = r_out_cls;
    assign o_result.win_score  = r_out_score;

endmodule

`default_nettype wire

@@ hw/rtl/bnb_ram.sv @@
`default_nettype none

module bnb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/bnb_seq.sv @@
`default_nettype none

module bnb_seq #(
    parameter int MAX_CLASSES  = bnb_pkg::MAX_CLASSES_DEF,
    parameter int MAX_FEATURES = bnb_pkg::MAX_FEATURES_DEF
) (
    input  wire                                          i_clk,
    input  wire                                          i_rst_n,
    input  wire                                          i_start,
    input  wire  [bnb_pkg::CC_W-1:0]                     i_nc,
    input  wire  [$clog2(MAX_FEATURES+1)-1:0]            i_nf,
    input  wire  [bnb_pkg::BITS_W-1:0]                   i_bits,
    output logic [$clog2(MAX_CLASSES)-1:0]               o_prior_addr,
    output logic [$clog2(MAX_CLASSES*MAX_FEATURES)-1:0]  o_feat_addr,
    output bnb_pkg::t_tag                                o_tag
);

    import bnb_pkg::*;

    localparam int JW  = $clog2(MAX_FEATURES+1);
    localparam int AW  = $clog2(MAX_CLASSES*MAX_FEATURES);
    localparam int CAW = $clog2(MAX_CLASSES);

    logic              r_act, n_act;
    logic [CLS_W-1:0]  r_cls, n_cls;
    logic [JW-1:0]     r_j, n_j;
    logic [AW-1:0]     r_faddr, n_faddr;
    logic [AW-1:0]     r_cbase, n_cbase;
    logic [BITS_W-1:0] r_bits, n_bits;
    logic [BITS_W-1:0] r_sh, n_sh;
    logic [CC_W-1:0]   r_nc, n_nc;
    logic [JW-1:0]     r_nf, n_nf;

    logic nofeat, last, lastc;

    // Position within the class/feature sweep
    always_comb begin
        nofeat = (r_nf == '0);
        last   = nofeat || ((r_j + JW'(1)) == r_nf);
        lastc  = last && ((CC_W'(r_cls) + CC_W'(1)) == r_nc);
    end

    // Read addresses and tag for the current step
    always_comb begin
        o_prior_addr = CAW'(r_cls);
        o_feat_addr  = r_faddr;
        o_tag.valid  = r_act;
        o_tag.first  = (r_j == '0);
        o_tag.last   = last;
        o_tag.lastc  = lastc;
        o_tag.nofeat = nofeat;
        o_tag.on     = r_sh[0];
        o_tag.cls    = r_cls;
    end

    // Load a sweep on start; then step to the next feature, or to the next class at the end of a row
    always_comb begin
        n_act   = r_act;
        n_cls   = r_cls;
        n_j     = r_j;
        n_faddr = r_faddr;
        n_cbase = r_cbase;
        n_bits  = r_bits;
        n_sh    = r_sh;
        n_nc    = r_nc;
        n_nf    = r_nf;
        if (i_start) begin
            n_act   = 1'b1;
            n_cls   = '0;
            n_j     = '0;
            n_faddr = '0;
            n_cbase = '0;
            n_bits  = i_bits;
            n_sh    = i_bits;
            n_nc    = i_nc;
            n_nf    = i_nf;
        end else if (r_act) begin
            if (last) begin
                n_cls   = r_cls + CLS_W'(1);
                n_j     = '0;
                n_cbase = r_cbase + AW'(MAX_FEATURES);
                n_faddr = r_cbase + AW'(MAX_FEATURES);
                n_sh    = r_bits;
                if (lastc) begin
                    n_act = 1'b0;
                end
            end else begin
                n_j     = r_j + JW'(1);
                n_faddr = r_faddr + AW'(1);
                n_sh    = r_sh >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else begin
            r_act <= n_act;
        end
        r_cls   <= n_cls;
        r_j     <= n_j;
        r_faddr <= n_faddr;
        r_cbase <= n_cbase;
        r_bits  <= n_bits;
        r_sh    <= n_sh;
        r_nc    <= n_nc;
        r_nf    <= n_nf;
    end

endmodule

`default_nettype wire

@@ hw/rtl/bnb_acc.sv @@
`default_nettype none

module bnb_acc (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire bnb_pkg::t_tag               i_tag,
    input  wire  [bnb_pkg::VAL_W-1:0]        i_prior,
    input  wire  [bnb_pkg::VAL_W-1:0]        i_present,
    input  wire  [bnb_pkg::VAL_W-1:0]        i_absent,
    output logic                             o_done,
    output logic [bnb_pkg::CLS_W-1:0]        o_best_cls,
    output logic signed [bnb_pkg::VAL_W-1:0] o_win_score
);

    import bnb_pkg::*;

    t_tag                     r_t1;
    logic signed [VAL_W-1:0]  r_acc;
    logic                     r_d2;
    logic                     r_lastc2;
    logic [CLS_W-1:0]         r_cls2;
    logic                     r_done;
    logic [CLS_W-1:0]         r_best_cls;
    logic signed [VAL_W-1:0]  r_best;

    logic signed [VAL_W-1:0]  base, term, n_acc;
    logic signed [VAL_W:0]    sum;

    // Shared saturating adder: prior or running score plus one table term, or zero with no features
    always_comb begin
        base = r_t1.first ? $signed(i_prior) : r_acc;
        if (r_t1.nofeat) begin
            term = '0;
        end else if (r_t1.on) begin
            term = $signed(i_present);
        end else begin
            term = $signed(i_absent);
        end
        sum = {base[VAL_W-1], base} + {term[VAL_W-1], term};
        if (sum[VAL_W] != sum[VAL_W-1]) begin
            n_acc = sum[VAL_W] ? S32_MIN : S32_MAX;
        end else begin
            n_acc = sum[VAL_W-1:0];
        end
    end

    // Tag aligned with read data, then accumulate, then compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1.valid <= 1'b0;
            r_d2       <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_t1.valid <= i_tag.valid;
            r_d2       <= r_t1.valid && r_t1.last;
            r_done     <= r_d2 && r_lastc2;
        end
        r_t1.first  <= i_tag.first;
        r_t1.last   <= i_tag.last;
        r_t1.lastc  <= i_tag.lastc;
        r_t1.nofeat <= i_tag.nofeat;
        r_t1.on     <= i_tag.on;
        r_t1.cls    <= i_tag.cls;
        if (r_t1.valid) begin
            r_acc <= n_acc;
        end
        r_cls2   <= r_t1.cls;
        r_lastc2 <= r_t1.lastc;
        // strictly greater wins; class zero always seeds the best
        if (r_d2 && ((r_cls2 == '0) || (r_acc > r_best))) begin
            r_best     <= r_acc;
            r_best_cls <= r_cls2;
        end
    end

    assign o_done      = r_done;
    assign o_best_cls  = r_best_cls;
    assign o_win_score = r_best;

endmodule

`default_nettype wire

@@ sim/tb_bernoulli_bayes_classifier.sv @@
`default_nettype none

module tb_bernoulli_bayes_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import bnb_pkg::*;

    localparam int NUM_CLASSES   = MAX_CLASSES_DEF;
    localparam int NUM_FEATURES  = MAX_FEATURES_DEF;
    localparam int TBL_DEPTH     = NUM_CLASSES * NUM_FEATURES;
    localparam int QUIET_LIMIT   = 5000;   // cycles with no transaction anywhere
    localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
    localparam int SETTLE_CYCLES = 8;      // pause after the queues drain
    localparam int END_PAUSE     = 20;
    localparam int REPORT_MAX    = 10;

    // Select value that names no table; the block drops such writes
    localparam logic [SEL_W-1:0] TBL_NONE = 2'd3;

    typedef struct {
        logic [KIND_W-1:0]        kind;
        logic [SEL_W-1:0]         table_sel;
        logic [CLS_W-1:0]         class_index;
        logic [FIDX_W-1:0]        feature_index;
        logic signed [VAL_W-1:0]  entry_value;
        logic [BITS_W-1:0]        feature_bits;
    } t_nb_item;

    typedef struct {
        logic [CLS_W-1:0]         best_class;
        logic signed [VAL_W-1:0]  win_score;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;

    bnb_item_if   item_bus();
    bnb_cfg_if    cfg_bus();
    bnb_result_if result_bus();

    bernoulli_bayes_classifier uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .i_cfg    (cfg_bus),
        .o_result (result_bus)
    );

    // Outgoing items and verdicts still owed by the block
    t_nb_item item_backlog[$];
    t_verdict verdicts_due[$];

    // Shadow of the block: log tables and its two registers
    logic signed [VAL_W-1:0] log_prior[NUM_CLASSES];
    logic signed [VAL_W-1:0] log_present[TBL_DEPTH];
    logic signed [VAL_W-1:0] log_absent[TBL_DEPTH];
    logic [CC_W-1:0]         classes_reg  = CLASS_COUNT_RST;
    logic [FC_W-1:0]         features_reg = FEATURE_COUNT_RST;

    // Which entries the stimulus has loaded so far, and the sizes now in use
    bit prior_loaded[NUM_CLASSES];
    bit present_loaded[TBL_DEPTH];
    bit absent_loaded[TBL_DEPTH];
    int gen_classes  = 2;
    int gen_features = 2;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int items_queued    = 0;
    int writes_accepted = 0;
    int scores_accepted = 0;
    int verdicts_seen   = 0;
    int mismatches      = 0;
    int quiet_cycles    = 0;
    int widest_classes  = 0;
    int widest_features = 0;

    t_nb_item drive_item;

    // Saturating Q16.16 accumulate
    function automatic logic signed [VAL_W-1:0] sat_accumulate(
        input logic signed [VAL_W-1:0] acc,
        input logic signed [VAL_W-1:0] term
    );
        logic [VAL_W:0] sum;
        sum = {acc[VAL_W-1], acc} + {term[VAL_W-1], term};
        if (sum[VAL_W] != sum[VAL_W-1])
            return sum[VAL_W] ? S32_MIN : S32_MAX;
        return sum[VAL_W-1:0];
    endfunction

    // Apply one item to the shadow tables; returns 1 with the verdict for a classify
    function automatic bit classify_or_load(input t_nb_item it, output t_verdict v);
        int nc;
        int nf;
        int addr;
        logic signed [VAL_W-1:0] acc;
        v.best_class = '0;
        v.win_score  = '0;
        if (it.kind == KIND_WRITE) begin
            addr = int'(it.class_index) * NUM_FEATURES + int'(it.feature_index);
            case (it.table_sel)
                TBL_PRIOR:   log_prior[it.class_index] = it.entry_value;
                TBL_PRESENT: log_present[addr] = it.entry_value;
                TBL_ABSENT:  log_absent[addr] = it.entry_value;
                default: ;
            endcase
            return 1'b0;
        end
        // zero classes counts as one, counts saturate at the table sizes
        nc = (classes_reg == 0) ? 1 : int'(classes_reg);
        if (nc > NUM_CLASSES)
            nc = NUM_CLASSES;
        nf = int'(features_reg);
        if (nf > NUM_FEATURES)
            nf = NUM_FEATURES;
        for (int c = 0; c < nc; c++) begin
            acc = log_prior[c];
            for (int j = 0; j < nf; j++) begin
                addr = c * NUM_FEATURES + j;
                acc = sat_accumulate(acc, it.feature_bits[j] ? log_present[addr]
                                                             : log_absent[addr]);
            end
            // strict compare keeps the lowest class on ties
            if (c == 0 || acc > v.win_score) begin
                v.win_score  = acc;
                v.best_class = CLS_W'(c);
            end
        end
        return 1'b1;
    endfunction

    // Log values: rails, small values that tie, mid-size and full-range
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return S32_MAX;
            1: return S32_MIN;
            2: return '0;
            3, 4, 5: return int'($urandom_range(8)) - 4;
            6, 7: return int'($urandom_range(20'hFFFFF)) - 524288;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [BITS_W-1:0] pick_bits();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return BITS_W'(1) << $urandom_range(BITS_W - 1);
            3: return ~(BITS_W'(1) << $urandom_range(BITS_W - 1));
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_write(
        input logic [SEL_W-1:0]        sel,
        input logic [CLS_W-1:0]        cls,
        input logic [FIDX_W-1:0]       feat,
        input logic signed [VAL_W-1:0] value
    );
        t_nb_item it;
        int addr;
        it.kind          = KIND_WRITE;
        it.table_sel     = sel;
        it.class_index   = cls;
        it.feature_index = feat;
        it.entry_value   = value;
        it.feature_bits  = $urandom();
        item_backlog.push_back(it);
        addr = int'(cls) * NUM_FEATURES + int'(feat);
        case (sel)
            TBL_PRIOR:   prior_loaded[cls] = 1'b1;
            TBL_PRESENT: present_loaded[addr] = 1'b1;
            TBL_ABSENT:  absent_loaded[addr] = 1'b1;
            default: ;
        endcase
        if (sel != TBL_NONE)
            items_queued++;
    endtask

    // Load any entry the current sizes will read, then queue the classify
    task automatic queue_classify(input logic [BITS_W-1:0] bits);
        t_nb_item it;
        for (int c = 0; c < gen_classes; c++) begin
            if (!prior_loaded[c])
                queue_write(TBL_PRIOR, CLS_W'(c), FIDX_W'($urandom()), pick_value());
            for (int f = 0; f < gen_features; f++) begin
                if (!present_loaded[c * NUM_FEATURES + f])
                    queue_write(TBL_PRESENT, CLS_W'(c), FIDX_W'(f), pick_value());
                if (!absent_loaded[c * NUM_FEATURES + f])
                    queue_write(TBL_ABSENT, CLS_W'(c), FIDX_W'(f), pick_value());
            end
        end
        it.kind          = KIND_CLASSIFY;
        it.table_sel     = SEL_W'($urandom());
        it.class_index   = CLS_W'($urandom());
        it.feature_index = FIDX_W'($urandom());
        it.entry_value   = $urandom();
        it.feature_bits  = bits;
        item_backlog.push_back(it);
        items_queued++;
    endtask

    task automatic random_op();
        logic [SEL_W-1:0]  sel;
        logic [CLS_W-1:0]  cls;
        logic [FIDX_W-1:0] feat;
        int r;
        r = $urandom_range(99);
        case ($urandom_range(2))
            0: sel = TBL_PRIOR;
            1: sel = TBL_PRESENT;
            default: sel = TBL_ABSENT;
        endcase
        // half the writes land in the part now in use, the rest anywhere
        if ($urandom_range(1)) begin
            cls  = CLS_W'($urandom_range(gen_classes - 1));
            feat = FIDX_W'($urandom_range(gen_features > 0 ? gen_features - 1 : 0));
        end else begin
            cls  = CLS_W'($urandom());
            feat = FIDX_W'($urandom());
        end
        if (r < 45)
            queue_classify(pick_bits());
        else if (r < 92)
            queue_write(sel, cls, feat, pick_value());
        else
            queue_write(TBL_NONE, cls, feat, $urandom());
    endtask

    task automatic write_reg(
        input logic [CFG_IDX_W-1:0] idx,
        input logic [CFG_DAT_W-1:0] data
    );
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic wait_quiet();
        do @(negedge i_clk);
        while (item_backlog.size() != 0 || item_bus.valid || verdicts_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(
        input logic [CFG_DAT_W-1:0] cc_data,
        input logic [CFG_DAT_W-1:0] fc_data
    );
        int cc;
        cc = int'(cc_data[CC_W-1:0]);
        write_reg(CFG_CLASS_COUNT, cc_data);
        write_reg(CFG_FEATURE_COUNT, fc_data);
        gen_classes  = (cc == 0) ? 1 : (cc > NUM_CLASSES ? NUM_CLASSES : cc);
        gen_features = (int'(fc_data) > NUM_FEATURES) ? NUM_FEATURES : int'(fc_data);
        if (gen_classes > widest_classes)
            widest_classes = gen_classes;
        if (gen_features > widest_features)
            widest_features = gen_features;
    endtask

    task automatic run_phase(
        input int cc,
        input int fc,
        input int idle_pct,
        input int stall_pct,
        input int n_items,
        input bit long_hold
    );
        int start;
        wait_quiet();
        // bit 5 of the class count write is dropped by the block
        apply_setting({1'($urandom_range(1)), CC_W'(cc)}, CFG_DAT_W'(fc));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (long_hold)
            hold_req <= hold_req + 1;
        start = items_queued;
        while (items_queued - start < n_items)
            random_op();
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Item driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_bus.valid <= 1'b0;
        end else if (!item_bus.valid || item_bus.ready) begin
            if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drive_item = item_backlog.pop_front();
                item_bus.valid         <= 1'b1;
                item_bus.kind          <= drive_item.kind;
                item_bus.table_sel     <= drive_item.table_sel;
                item_bus.class_index   <= drive_item.class_index;
                item_bus.feature_index <= drive_item.feature_index;
                item_bus.entry_value   <= drive_item.entry_value;
                item_bus.feature_bits  <= drive_item.feature_bits;
            end else begin
                item_bus.valid <= 1'b0;
            end
        end
    end

    // Long hold-off counter
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result sink
    always @(posedge i_clk) begin
        if (!i_rst_n)
            result_bus.ready <= 1'b0;
        else
            result_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: track register writes and items, check verdicts, watch for a hang
    always @(posedge i_clk) begin : monitor
        t_nb_item seen;
        t_verdict owed;
        bit       moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (cfg_bus.valid && cfg_bus.ready) begin
                moved = 1'b1;
                case (cfg_bus.index)
                    CFG_CLASS_COUNT:   classes_reg  = cfg_bus.data[CC_W-1:0];
                    CFG_FEATURE_COUNT: features_reg = cfg_bus.data[FC_W-1:0];
                    default: ;
                endcase
            end
            if (item_bus.valid && item_bus.ready) begin
                moved = 1'b1;
                seen.kind          = item_bus.kind;
                seen.table_sel     = item_bus.table_sel;
                seen.class_index   = item_bus.class_index;
                seen.feature_index = item_bus.feature_index;
                seen.entry_value   = item_bus.entry_value;
                seen.feature_bits  = item_bus.feature_bits;
                if (classify_or_load(seen, owed)) begin
                    verdicts_due.push_back(owed);
                    scores_accepted++;
                end else begin
                    writes_accepted++;
                end
            end
            if (result_bus.valid && result_bus.ready) begin
                moved = 1'b1;
                verdicts_seen++;
                if (verdicts_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: result with none owed: class %0d score %0d",
                                 $realtime, result_bus.best_class, result_bus.win_score);
                end else begin
                    owed = verdicts_due.pop_front();
                    if (result_bus.best_class !== owed.best_class ||
                        result_bus.win_score !== owed.win_score) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: result %0d: class exp %0d got %0d, score exp %0d got %0d",
                                     $realtime, verdicts_seen, owed.best_class,
                                     result_bus.best_class, owed.win_score,
                                     result_bus.win_score);
                    end
                end
            end
            if (moved) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("%0t: no transaction for %0d cycles, %0d results owed",
                             $realtime, QUIET_LIMIT, verdicts_due.size());
                    $display("tb_bernoulli_bayes_classifier: errors");
                    $finish;
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        i_rst_n                = 1'b0;
        item_bus.valid         = 1'b0;
        item_bus.kind          = KIND_WRITE;
        item_bus.table_sel     = TBL_PRIOR;
        item_bus.class_index   = '0;
        item_bus.feature_index = '0;
        item_bus.entry_value   = '0;
        item_bus.feature_bits  = '0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = CFG_CLASS_COUNT;
        cfg_bus.data           = '0;
        result_bus.ready       = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: two classes, two features as after reset
        queue_write(TBL_PRIOR,   4'd0, 5'd0, S32_MAX);
        queue_write(TBL_PRIOR,   4'd1, 5'd0, S32_MAX);
        queue_write(TBL_PRESENT, 4'd0, 5'd0, S32_MAX);
        queue_write(TBL_PRESENT, 4'd0, 5'd1, 32'sd1);
        queue_write(TBL_ABSENT,  4'd0, 5'd0, 32'sd0);
        queue_write(TBL_ABSENT,  4'd0, 5'd1, 32'sd0);
        queue_write(TBL_PRESENT, 4'd1, 5'd0, 32'sd0);
        queue_write(TBL_PRESENT, 4'd1, 5'd1, 32'sd0);
        queue_write(TBL_ABSENT,  4'd1, 5'd0, S32_MIN);
        queue_write(TBL_ABSENT,  4'd1, 5'd1, S32_MIN);
        // both classes pinned at the top rail: tie goes to class 0
        queue_classify(32'h0000_0003);
        // class 1 drives through the bottom rail
        queue_classify(32'h0000_0000);
        queue_write(TBL_PRIOR,   4'd0, 5'd31, S32_MIN);
        // tie at -1 from opposite rails
        queue_classify(32'h0000_0001);
        // class 1 wins outright
        queue_classify(32'h0000_0002);
        // write to no table must leave class 0 alone
        queue_write(TBL_NONE,    4'd0, 5'd0, 32'sd12345);
        queue_classify(32'h0000_0002);
        // bits above the features in use do not count
        queue_classify(32'hFFFF_FFFC);

        // zero classes scores class 0 alone, zero features scores the prior
        wait_quiet();
        apply_setting(6'b10_0000, 6'd0);
        queue_classify(32'hFFFF_FFFF);
        queue_classify(32'h0000_0000);

        // Random phases: sizes, sender gaps, receiver stalls; a classify in the first full-size
        // phase loads all of the feature tables
        run_phase(3,  4,  0,  0,  30, 1'b0);
        run_phase(2,  1,  62, 0,  30, 1'b0);
        run_phase(6,  9,  0,  62, 30, 1'b0);
        run_phase(1,  0,  32, 32, 25, 1'b0);
        run_phase(0,  3,  0,  0,  25, 1'b1);
        run_phase(16, 32, 0,  0,  50, 1'b0);
        run_phase(31, 63, 32, 32, 25, 1'b0);
        run_phase(4,  32, 62, 0,  25, 1'b0);
        run_phase(16, 1,  0,  62, 25, 1'b0);
        run_phase(9,  17, 0,  0,  30, 1'b0);

        wait_quiet();
        repeat (END_PAUSE) @(posedge i_clk);
        if (verdicts_due.size() != 0)
            mismatches += verdicts_due.size();

        $display("run: %0d table writes and %0d classifies accepted, %0d results checked",
                 writes_accepted, scores_accepted, verdicts_seen);
        $display("run: sizes up to %0d classes by %0d features, %0d mismatches",
                 widest_classes, widest_features, mismatches);
        if (mismatches == 0)
            $display("tb_bernoulli_bayes_classifier: clean");
        else
            $display("tb_bernoulli_bayes_classifier: errors");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/bnb_pkg.sv
hw/rtl/bnb_item_if.sv
hw/rtl/bnb_result_if.sv
hw/rtl/bnb_cfg_if.sv
hw/rtl/bnb_ram.sv
hw/rtl/bnb_seq.sv
hw/rtl/bnb_acc.sv
hw/rtl/bernoulli_bayes_classifier.sv
sim/tb_bernoulli_bayes_classifier.sv
